### hdl/eed_pkg.sv
// ---------------------------------------------------------------------------
// eed_pkg: shared types and constants for the elgamal unit
// Register indexes, controller commands and datapath status.
// ---------------------------------------------------------------------------
package eed_pkg;

   localparam int unsigned CSR_IDX_BITS = 2;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_MODULUS     = 2'd0,
      CSR_GENERATOR   = 2'd1,
      CSR_PRIVATE_KEY = 2'd2,
      CSR_UNUSED      = 2'd3
   } csr_idx_type;

   // operand selections for the datapath registers
   typedef enum logic [2:0] {
      SRC_ONE     = 3'd0,
      SRC_GEN     = 3'd1,
      SRC_C1      = 3'd2,
      SRC_ACC     = 3'd3,
      SRC_MSG     = 3'd4,
      SRC_C2      = 3'd5,
      SRC_Y       = 3'd6
   } src_type;

   typedef enum logic [2:0] {
      EXP_KEY   = 3'd0,
      EXP_NONCE = 3'd1,
      EXP_PM2   = 3'd2,
      EXP_ZERO  = 3'd3
   } exp_sel_type;

   typedef struct packed {
      logic        start;      // latch request
      logic        load_base;  // base <= source, reduced unless acc, y or one
      src_type     base_src;
      logic        load_acc;   // acc <= 1
      logic        load_exp;
      exp_sel_type exp_sel;
      logic        mul_acc;    // acc <= acc*base
      logic        mul_sq;     // base <= base*base
      logic        mul_out;    // acc <= operand * acc
      src_type     out_src;
      logic        shift_exp;
      logic        save_c1;    // keep acc as c1
      logic        save_y;     // keep acc as y
      logic        final_res;
   } dp_cmd_type;

   typedef struct packed {
      logic busy;      // multiplier or reducer working
      logic exp_zero;
      logic exp_lsb;
      logic mod_small; // modulus below two
   } dp_sts_type;

endpackage

### hdl/eed_modmul.sv
// ---------------------------------------------------------------------------
// eed_modmul: serial modular multiplier
// Shift-add of a*b mod m, one multiplier bit per cycle, a and b below m.
// ---------------------------------------------------------------------------
module eed_modmul #(
   parameter int unsigned WORD_BITS = 31
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [WORD_BITS-1:0] op_a,
   input  logic [WORD_BITS-1:0] op_b,
   input  logic [WORD_BITS-1:0] modulus,
   output logic                 busy,
   output logic                 done,
   output logic [WORD_BITS-1:0] result
);
   localparam int unsigned CNT_BITS = $clog2(WORD_BITS + 1);

   logic [WORD_BITS-1:0] a_ff, a_in, b_ff, b_in, r_ff, r_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic                 busy_ff, busy_in, done_ff, done_in;
   logic [WORD_BITS:0]   dbl, dbl_red, add, add_red;

   always_comb begin
      // horner from msb: r = 2r (+ a), reduce after each step
      dbl     = {r_ff, 1'b0};
      dbl_red = (dbl >= {1'b0, modulus}) ? dbl - {1'b0, modulus} : dbl;
      add     = dbl_red + {1'b0, a_ff};
      add_red = (add >= {1'b0, modulus}) ? add - {1'b0, modulus} : add;
      a_in    = a_ff;
      b_in    = b_ff;
      r_in    = r_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         a_in    = op_a;
         b_in    = op_b;
         r_in    = '0;
         cnt_in  = CNT_BITS'(WORD_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         r_in   = b_ff[WORD_BITS-1] ? add_red[WORD_BITS-1:0] : dbl_red[WORD_BITS-1:0];
         b_in   = {b_ff[WORD_BITS-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      r_ff   <= r_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign busy   = busy_ff;
   assign done   = done_ff;
   assign result = r_ff;
endmodule

### hdl/eed_datapath.sv
// ---------------------------------------------------------------------------
// eed_datapath: operand registers, exponent shifter, reducer and multiplier
// Serial reduction of inputs, square-and-multiply registers, result holding.
// ---------------------------------------------------------------------------
module eed_datapath
   import eed_pkg::*;
#(
   parameter int unsigned WORD_BITS = 31
) (
   input  logic                 clock,
   input  logic                 reset,
   input  dp_cmd_type           cmd,
   output dp_sts_type           sts,
   input  logic [WORD_BITS-1:0] modulus,
   input  logic [WORD_BITS-1:0] generator,
   input  logic [WORD_BITS-1:0] private_key,
   input  logic                 req_kind,
   input  logic [WORD_BITS-1:0] req_message,
   input  logic [WORD_BITS-1:0] req_nonce,
   input  logic [WORD_BITS-1:0] req_cipher_first_in,
   input  logic [WORD_BITS-1:0] req_cipher_second_in,
   output logic [WORD_BITS-1:0] res_c1,
   output logic [WORD_BITS-1:0] res_c2,
   output logic [WORD_BITS-1:0] res_pt
);
   localparam int unsigned CNT_BITS = $clog2(WORD_BITS + 1);

   logic                 kind_ff;
   logic [WORD_BITS-1:0] msg_ff, nonce_ff, c1i_ff, c2i_ff;
   logic [WORD_BITS-1:0] base_ff, acc_ff, exp_ff, c1_ff, y_ff;
   logic [WORD_BITS-1:0] c1_in, c2_in, pt_in;
   logic [WORD_BITS-1:0] c1o_ff, c2o_ff, pto_ff;

   // serial reducer: restoring remainder, one bit a cycle
   logic [WORD_BITS-1:0] rsrc_ff, rrem_ff;
   logic [CNT_BITS-1:0]  rcnt_ff;
   logic                 rbusy_ff, red_start;
   logic [WORD_BITS:0]   rsh;
   logic [WORD_BITS-1:0] red_src_val;

   logic                 m_start, m_busy, m_done;
   logic [WORD_BITS-1:0] m_a, m_b, m_res;
   logic                 m_kind_ff; // 0 acc*base / out, 1 base*base

   always_comb begin
      case (cmd.base_src)
         SRC_GEN: red_src_val = generator;
         SRC_C1:  red_src_val = c1i_ff;
         SRC_MSG: red_src_val = msg_ff;
         SRC_C2:  red_src_val = c2i_ff;
         default: red_src_val = acc_ff;
      endcase
   end
   // plain copies (acc, y, one) skip the reducer
   assign red_start = cmd.load_base &&
                      (cmd.base_src == SRC_GEN || cmd.base_src == SRC_C1 ||
                       cmd.base_src == SRC_MSG || cmd.base_src == SRC_C2);
   assign rsh = {rrem_ff, rsrc_ff[WORD_BITS-1]};

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         kind_ff  <= req_kind;
         msg_ff   <= req_message;
         nonce_ff <= req_nonce;
         c1i_ff   <= req_cipher_first_in;
         c2i_ff   <= req_cipher_second_in;
      end
      if (red_start) begin
         rsrc_ff <= red_src_val;
         rrem_ff <= '0;
         rcnt_ff <= CNT_BITS'(WORD_BITS);
      end else if (rbusy_ff) begin
         rsrc_ff <= {rsrc_ff[WORD_BITS-2:0], 1'b0};
         rrem_ff <= (rsh >= {1'b0, modulus}) ? WORD_BITS'(rsh - {1'b0, modulus})
                                             : rsh[WORD_BITS-1:0];
         rcnt_ff <= rcnt_ff - 1'b1;
      end
      if (rbusy_ff && rcnt_ff == CNT_BITS'(1)) begin
         base_ff <= (rsh >= {1'b0, modulus}) ? WORD_BITS'(rsh - {1'b0, modulus})
                                             : rsh[WORD_BITS-1:0];
      end else if (cmd.load_base && !red_start) begin
         base_ff <= (cmd.base_src == SRC_ONE) ? WORD_BITS'(1) :
                    (cmd.base_src == SRC_Y)   ? y_ff : acc_ff;
      end
      if (cmd.load_acc) acc_ff <= WORD_BITS'(1);
      if (m_done) begin
         if (m_kind_ff) base_ff <= m_res;
         else           acc_ff  <= m_res;
      end
      if (cmd.load_exp) begin
         case (cmd.exp_sel)
            EXP_KEY:   exp_ff <= private_key;
            EXP_NONCE: exp_ff <= nonce_ff;
            EXP_PM2:   exp_ff <= modulus - WORD_BITS'(2);
            default:   exp_ff <= '0;
         endcase
      end else if (cmd.shift_exp) begin
         exp_ff <= exp_ff >> 1;
      end
      if (cmd.save_c1) c1_ff <= acc_ff;
      if (cmd.save_y)  y_ff  <= acc_ff;
      if (cmd.mul_acc || cmd.mul_out) m_kind_ff <= 1'b0;
      else if (cmd.mul_sq)            m_kind_ff <= 1'b1;
      if (cmd.final_res) begin
         c1o_ff <= c1_in;
         c2o_ff <= c2_in;
         pto_ff <= pt_in;
      end
      if (reset) rbusy_ff <= 1'b0;
      else if (red_start) rbusy_ff <= 1'b1;
      else if (rbusy_ff && rcnt_ff == CNT_BITS'(1)) rbusy_ff <= 1'b0;
   end

   // out multiply uses base (reduced operand) times acc
   assign m_start = cmd.mul_acc || cmd.mul_sq || cmd.mul_out;
   assign m_a     = cmd.mul_sq ? base_ff : acc_ff;
   assign m_b     = base_ff;

   eed_modmul #(.WORD_BITS(WORD_BITS)) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (m_start),
      .op_a    (m_a),
      .op_b    (m_b),
      .modulus (modulus),
      .busy    (m_busy),
      .done    (m_done),
      .result  (m_res)
   );

   always_comb begin
      c1_in = '0;
      c2_in = '0;
      pt_in = '0;
      if (!sts.mod_small) begin
         if (kind_ff) pt_in = acc_ff;
         else begin
            c1_in = c1_ff;
            c2_in = acc_ff;
         end
      end
   end

   // work started by a command shows up in the registers in the cycle after it
   assign sts.busy      = m_busy | m_done | rbusy_ff;
   assign sts.exp_zero  = (exp_ff == '0);
   assign sts.exp_lsb   = exp_ff[0];
   assign sts.mod_small = (modulus < WORD_BITS'(2));
   assign res_c1 = c1o_ff;
   assign res_c2 = c2o_ff;
   assign res_pt = pto_ff;
   // the out-source select has no use in this datapath
   logic unused_ok;
   assign unused_ok = ^{cmd.out_src};
endmodule

### hdl/eed_ctrl.sv
// ---------------------------------------------------------------------------
// eed_ctrl: sequencer for the elgamal unit
// Runs the power steps for encrypt or decrypt and the output handshake.
// ---------------------------------------------------------------------------
module eed_ctrl
   import eed_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_kind,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output dp_cmd_type cmd,
   input  dp_sts_type sts
);
   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_SETUP = 9'b000000010,
      ST_WAIT  = 9'b000000100,
      ST_TEST  = 9'b000001000,
      ST_SQ    = 9'b000010000,
      ST_NEXT  = 9'b000100000,
      ST_PHASE = 9'b001000000,
      ST_DONE  = 9'b010000000,
      ST_OUT   = 9'b100000000
   } state_type;

   // phases: encrypt y=g^x, c1=g^k, t=y^k, c2=m*t; decrypt s=c1^x, s^(p-2), b*sinv
   typedef enum logic [2:0] {
      PH_Y   = 3'd0,
      PH_C1  = 3'd1,
      PH_T   = 3'd2,
      PH_C2  = 3'd3,
      PH_S   = 3'd4,
      PH_INV = 3'd5,
      PH_PT  = 3'd6
   } phase_type;

   state_type state_ff, state_in, ret_ff, ret_in;
   phase_type ph_ff, ph_in;
   logic      kind_ff, kind_in;
   logic      valid_ff, valid_in;

   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      ph_in    = ph_ff;
      kind_in  = kind_ff;
      valid_in = valid_ff;
      cmd      = '0;
      cmd.base_src = SRC_ONE;
      cmd.out_src  = SRC_ONE;
      cmd.exp_sel  = EXP_ZERO;
      if (valid_ff && !rsp_stall) valid_in = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               kind_in   = req_kind;
               ph_in     = req_kind ? PH_S : PH_Y;
               state_in  = ST_SETUP;
            end
         end
         ST_SETUP: begin
            ret_in   = ST_TEST;
            state_in = ST_WAIT;
            cmd.load_acc  = 1'b1;
            cmd.load_exp  = 1'b1;
            cmd.load_base = 1'b1;
            case (ph_ff)
               PH_Y:    begin cmd.base_src = SRC_GEN; cmd.exp_sel = EXP_KEY;   end
               PH_C1:   begin cmd.base_src = SRC_GEN; cmd.exp_sel = EXP_NONCE; end
               PH_T:    begin cmd.base_src = SRC_Y;   cmd.exp_sel = EXP_NONCE;
                              cmd.save_c1 = 1'b1; end
               PH_S:    begin cmd.base_src = SRC_C1;  cmd.exp_sel = EXP_KEY;   end
               PH_INV:  begin cmd.base_src = SRC_ACC; cmd.exp_sel = EXP_PM2;   end
               PH_C2:   begin cmd.base_src = SRC_MSG; cmd.load_acc = 1'b0;
                              cmd.load_exp = 1'b0; ret_in = ST_DONE; end
               default: begin cmd.base_src = SRC_C2;  cmd.load_acc = 1'b0;
                              cmd.load_exp = 1'b0; ret_in = ST_DONE; end
            endcase
            // no field: the zero result is written once the output is free
            if (sts.mod_small) begin
               cmd = '0;
               cmd.base_src = SRC_ONE;
               cmd.out_src  = SRC_ONE;
               cmd.exp_sel  = EXP_ZERO;
               state_in = ST_OUT;
            end
         end
         ST_WAIT: begin
            if (!sts.busy) state_in = ret_ff;
         end
         ST_TEST: begin
            if (sts.exp_zero) state_in = ST_PHASE;
            else begin
               if (sts.exp_lsb) begin
                  cmd.mul_acc = 1'b1;
                  ret_in = ST_SQ;
                  state_in = ST_WAIT;
               end else state_in = ST_SQ;
            end
         end
         ST_SQ: begin
            cmd.mul_sq = 1'b1;
            ret_in   = ST_NEXT;
            state_in = ST_WAIT;
         end
         ST_NEXT: begin
            cmd.shift_exp = 1'b1;
            state_in = ST_TEST;
         end
         ST_PHASE: begin
            // after t phase acc=t; base for c2 comes from m. y reload after Y
            case (ph_ff)
               PH_Y:    begin cmd.save_y = 1'b1; ph_in = PH_C1; end
               PH_C1:   ph_in = PH_T;
               PH_T:    ph_in = PH_C2;
               PH_S:    ph_in = PH_INV;
               default: ph_in = PH_PT;
            endcase
            state_in = ST_SETUP;
         end
         ST_DONE: begin
            // base holds reduced m or c2, acc the power: one product
            cmd.mul_out = 1'b1;
            ret_in   = ST_OUT;
            state_in = ST_WAIT;
         end
         ST_OUT: begin
            if (!valid_ff || !rsp_stall) begin
               if (!cmd.final_res) cmd.final_res = 1'b1;
               valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ret_ff   <= ST_IDLE;
         ph_ff    <= PH_Y;
         kind_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         ph_ff    <= ph_in;
         kind_ff  <= kind_in;
         valid_ff <= valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE) || (kind_ff & 1'b0);
   assign rsp_valid = valid_ff;
endmodule

### hdl/elgamal_encrypt_decrypt.sv
// ---------------------------------------------------------------------------
// elgamal_encrypt_decrypt: elgamal encrypt / decrypt over GF(p)
// One item at a time. An encrypt computes y=g^x, c1=g^k, y^k and one
// product; a decrypt computes c1^x, its power p-2 and one product. Every
// modular product runs through one shift-add multiplier, and each power
// takes up to two products and one exponent shift per exponent bit, plus
// a serial reduction of each input operand. The input stalls while an item
// is in work; a finished beat waits in the output register.
// ---------------------------------------------------------------------------
module elgamal_encrypt_decrypt
   import eed_pkg::*;
#(
   parameter int unsigned WORD_BITS = 31
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    req_kind,
   input  logic [WORD_BITS-1:0]    req_message,
   input  logic [WORD_BITS-1:0]    req_nonce,
   input  logic [WORD_BITS-1:0]    req_cipher_first_in,
   input  logic [WORD_BITS-1:0]    req_cipher_second_in,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [WORD_BITS-1:0]    rsp_cipher_first,
   output logic [WORD_BITS-1:0]    rsp_cipher_second,
   output logic [WORD_BITS-1:0]    rsp_plain_text,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [WORD_BITS-1:0]    csr_data
);
   logic [WORD_BITS-1:0] modulus_ff, generator_ff, private_key_ff;
   dp_cmd_type cmd;
   dp_sts_type sts;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff     <= WORD_BITS'(23);
         generator_ff   <= WORD_BITS'(5);
         private_key_ff <= WORD_BITS'(6);
      end else if (csr_valid && csr_ready) begin
         case (csr_idx_type'(csr_index))
            CSR_MODULUS:     modulus_ff     <= csr_data;
            CSR_GENERATOR:   generator_ff   <= csr_data;
            CSR_PRIVATE_KEY: private_key_ff <= csr_data;
            default: ;
         endcase
      end
   end

   eed_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_kind),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   eed_datapath #(.WORD_BITS(WORD_BITS)) u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .sts                  (sts),
      .modulus              (modulus_ff),
      .generator            (generator_ff),
      .private_key          (private_key_ff),
      .req_kind             (req_kind),
      .req_message          (req_message),
      .req_nonce            (req_nonce),
      .req_cipher_first_in  (req_cipher_first_in),
      .req_cipher_second_in (req_cipher_second_in),
      .res_c1               (rsp_cipher_first),
      .res_c2               (rsp_cipher_second),
      .res_pt               (rsp_plain_text)
   );

   // a stalled result beat stays valid and unchanged
   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_cipher_first) &&
                                 $stable(rsp_cipher_second) && $stable(rsp_plain_text))
      else $error("pending result dropped or changed");

   // encrypt results never carry plain text and vice versa
   a_fields_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_plain_text == '0) ||
                    (rsp_cipher_first == '0 && rsp_cipher_second == '0))
      else $error("encrypt and decrypt fields both set");

   // an accepted request stalls the input on the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input not stalled after accept");
endmodule

### sim/tb_elgamal_encrypt_decrypt.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_elgamal_encrypt_decrypt: self-checking bench for the elgamal unit
// Drives random and directed encrypt/decrypt beats through several register
// settings, predicts each result with a behavioral power/multiply model and
// compares every output beat in order, with random idling on both channels.
// ---------------------------------------------------------------------------
module tb_elgamal_encrypt_decrypt;
   import eed_pkg::*;

   localparam int unsigned WB = 31;
   localparam int unsigned LIMIT = 4_000_000;
   localparam logic KIND_ENC = 1'b0;
   localparam logic KIND_DEC = 1'b1;

   typedef logic [WB-1:0] word_t;

   typedef struct packed {
      logic  kind;
      word_t message;
      word_t nonce;
      word_t c1_in;
      word_t c2_in;
   } crypt_req_t;

   typedef struct packed {
      word_t c1;
      word_t c2;
      word_t pt;
   } crypt_rsp_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_kind = 1'b0;
   word_t req_message = '0, req_nonce = '0, req_cipher_first_in = '0;
   word_t req_cipher_second_in = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   word_t rsp_cipher_first, rsp_cipher_second, rsp_plain_text;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_BITS-1:0] csr_index = '0;
   word_t csr_data = '0;
   logic req_taken = 1'b0;

   elgamal_encrypt_decrypt #(.WORD_BITS(WB)) dut (.*);

   // predictor copy of the registers
   word_t p_mod = 23, p_gen = 5, p_key = 6;

   crypt_req_t pending_q[$];
   crypt_rsp_t expected_q[$];
   int unsigned errors = 0, mismatches = 0, checked = 0, n_enc = 0, n_dec = 0;
   int unsigned cycles = 0;
   int unsigned send_idle_pct = 0, recv_idle_pct = 0;
   int unsigned hold_cycles = 0;

   function automatic longint unsigned pow_mod(longint unsigned b, longint unsigned e,
                                              longint unsigned m);
      longint unsigned acc;
      acc = 1;
      b = b % m;
      while (e != 0) begin
         if (e[0]) acc = (acc * b) % m;
         b = (b * b) % m;
         e = e >> 1;
      end
      return acc % m;
   endfunction

   function automatic crypt_rsp_t predict_crypt(crypt_req_t r);
      crypt_rsp_t o;
      longint unsigned p, y, s;
      o = '0;
      p = p_mod;
      if (p >= 2) begin
         if (r.kind == KIND_ENC) begin
            y = pow_mod(p_gen, p_key, p);
            o.c1 = word_t'(pow_mod(p_gen, r.nonce, p));
            o.c2 = word_t'(((r.message % p) * pow_mod(y, r.nonce, p)) % p);
         end else begin
            s = pow_mod(r.c1_in, p_key, p);
            o.pt = word_t'(((r.c2_in % p) * pow_mod(s, p - 2, p)) % p);
         end
      end
      return o;
   endfunction

   initial forever #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // input beat taken at this rising edge
   always @(posedge clock) begin
      req_taken <= req_valid && !req_stall;
   end

   // driver: a beat moves on a rising edge with valid high and stall low
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_valid || req_taken) begin
            if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               crypt_req_t r;
               r = pending_q.pop_front();
               expected_q.push_back(predict_crypt(r));
               if (r.kind == KIND_ENC) n_enc++; else n_dec++;
               req_valid <= 1'b1;
               req_kind <= r.kind;
               req_message <= r.message;
               req_nonce <= r.nonce;
               req_cipher_first_in <= r.c1_in;
               req_cipher_second_in <= r.c2_in;
            end else begin
               req_valid <= 1'b0;
            end
         end
         if (hold_cycles != 0) begin
            hold_cycles <= hold_cycles - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         crypt_rsp_t exp_r;
         if (expected_q.size() == 0) begin
            errors++;
            $display("unexpected result beat c1=%0d c2=%0d pt=%0d",
                     rsp_cipher_first, rsp_cipher_second, rsp_plain_text);
         end else begin
            exp_r = expected_q.pop_front();
            checked++;
            if (exp_r.c1 !== rsp_cipher_first || exp_r.c2 !== rsp_cipher_second ||
                exp_r.pt !== rsp_plain_text) begin
               errors++;
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp c1=%0d c2=%0d pt=%0d got c1=%0d c2=%0d pt=%0d",
                           exp_r.c1, exp_r.c2, exp_r.pt, rsp_cipher_first,
                           rsp_cipher_second, rsp_plain_text);
            end
         end
      end
   end

   task automatic wait_drained();
      while (pending_q.size() != 0 || req_valid || expected_q.size() != 0)
         @(posedge clock);
      repeat (5000) @(posedge clock);
   endtask

   task automatic write_reg(csr_idx_type idx, word_t val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      if (idx == CSR_MODULUS) p_mod = val;
      else if (idx == CSR_GENERATOR) p_gen = val;
      else if (idx == CSR_PRIVATE_KEY) p_key = val;
   endtask

   function automatic word_t rnd_word();
      case ($urandom_range(5))
         0: return '0;
         1: return '1;
         2: return word_t'($urandom_range(40));
         default: return word_t'($urandom);
      endcase
   endfunction

   // random beats; most encrypts are followed by a decrypt of their ciphertext
   task automatic queue_random(int unsigned n);
      crypt_req_t r, d;
      crypt_rsp_t c;
      repeat (n) begin
         r = '{kind: $urandom_range(1), message: rnd_word(), nonce: rnd_word(),
               c1_in: rnd_word(), c2_in: rnd_word()};
         pending_q.push_back(r);
         if (r.kind == KIND_ENC && $urandom_range(2) != 0) begin
            c = predict_crypt(r);
            d = '{kind: KIND_DEC, message: rnd_word(), nonce: rnd_word(),
                  c1_in: c.c1, c2_in: c.c2};
            pending_q.push_back(d);
         end
      end
   endtask

   function automatic crypt_req_t mk(logic k, word_t m, word_t n, word_t a, word_t b);
      return '{kind: k, message: m, nonce: n, c1_in: a, c2_in: b};
   endfunction

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed beats at reset settings (p=23)
      pending_q.push_back(mk(KIND_ENC, 7, 0, '1, '1));         // zero nonce
      pending_q.push_back(mk(KIND_ENC, '1, '1, 0, 0));         // unreduced message
      pending_q.push_back(mk(KIND_ENC, 0, 3, 5, 5));
      pending_q.push_back(mk(KIND_DEC, '1, '1, 10, 20));
      pending_q.push_back(mk(KIND_DEC, 0, 0, '1, '1));         // unreduced c1, c2
      pending_q.push_back(mk(KIND_DEC, 0, 0, 23, 4));          // s of zero
      pending_q.push_back(mk(KIND_DEC, 0, 0, 0, 0));
      wait_drained();

      write_reg(CSR_MODULUS, '1);                              // 2^31-1, prime
      write_reg(CSR_GENERATOR, '1);                            // unreduced generator
      write_reg(CSR_PRIVATE_KEY, '1);
      write_reg(CSR_UNUSED, 31'h1234);                         // ignored
      pending_q.push_back(mk(KIND_ENC, '1, '1, 0, 0));
      pending_q.push_back(mk(KIND_DEC, 0, 0, '1, '1));
      wait_drained();
      write_reg(CSR_GENERATOR, 7);
      pending_q.push_back(mk(KIND_ENC, 31'h2AAAAAAA, 31'h55555555, 0, 0));
      pending_q.push_back(mk(KIND_DEC, 0, 0, 31'h55555555, 31'h2AAAAAAA));
      wait_drained();

      write_reg(CSR_MODULUS, 2);                               // p-2 of zero
      pending_q.push_back(mk(KIND_ENC, 1, 5, 0, 0));
      pending_q.push_back(mk(KIND_DEC, 0, 0, 1, 1));
      wait_drained();
      write_reg(CSR_MODULUS, 1);                               // no field
      pending_q.push_back(mk(KIND_ENC, 9, 9, 9, 9));
      pending_q.push_back(mk(KIND_DEC, 9, 9, 9, 9));
      wait_drained();
      write_reg(CSR_MODULUS, 0);
      write_reg(CSR_PRIVATE_KEY, 0);
      pending_q.push_back(mk(KIND_ENC, 3, 3, 3, 3));
      wait_drained();
      write_reg(CSR_MODULUS, 21);                              // not prime
      write_reg(CSR_GENERATOR, 0);
      write_reg(CSR_PRIVATE_KEY, 5);
      pending_q.push_back(mk(KIND_ENC, 4, 2, 0, 0));
      pending_q.push_back(mk(KIND_DEC, 0, 0, 4, 8));
      wait_drained();

      // random phase 1: large prime, sender idles a little
      write_reg(CSR_MODULUS, 31'd2147483629);
      write_reg(CSR_GENERATOR, 31'd2);
      write_reg(CSR_PRIVATE_KEY, word_t'($urandom));
      send_idle_pct = 13; recv_idle_pct = 56;
      queue_random(30);
      wait_drained();

      // random phase 2 with a long receiver hold
      write_reg(CSR_MODULUS, 31'd1000003);
      write_reg(CSR_GENERATOR, word_t'($urandom));
      write_reg(CSR_PRIVATE_KEY, word_t'($urandom));
      send_idle_pct = 56; recv_idle_pct = 13;
      queue_random(30);
      @(negedge clock);
      hold_cycles <= 20000;
      wait_drained();

      // random phase 3: small prime, no idling
      write_reg(CSR_MODULUS, 31'd101);
      write_reg(CSR_GENERATOR, 31'd2);
      write_reg(CSR_PRIVATE_KEY, word_t'($urandom));
      send_idle_pct = 0; recv_idle_pct = 0;
      queue_random(20);
      wait_drained();

      $display("covered %0d encrypt and %0d decrypt beats, %0d results checked",
               n_enc, n_dec, checked);
      $display("moduli: reset, 2^31-1, 2, 1, 0, 21 and random-key primes");
      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("%0d errors", errors);
         $display("tb: failure");
      end
      $finish;
   end

endmodule
